// ===== design/ppsch_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the process scheduler.
// No dependencies.
package ppsch_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    localparam logic [15:0] RESET_FIRST_ID = 16'd1000;
    localparam logic [7:0]  PRIO_MAX       = 8'hFF;
    localparam logic [11:0] RUN_MAX        = 12'hFFF;

    typedef enum logic [2:0] {
        CMD_CREATE   = 3'd0,
        CMD_SCHEDULE = 3'd1,
        CMD_SUSPEND  = 3'd2,
        CMD_WAKE     = 3'd3,
        CMD_SLICE    = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        PST_WAITING = 2'd0,
        PST_READY   = 2'd1,
        PST_RUNNING = 2'd2
    } t_pstate;

    typedef enum logic [1:0] {
        OP_NOP = 2'd0,
        OP_INS = 2'd1,
        OP_POP = 2'd2
    } t_chain_op;

    // process control block
    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  prio;
        logic [11:0] cpu;
        logic [11:0] run;
        logic        io;
        logic [7:0]  mem;
    } t_pcb;

    // what a chain cell shows its neighbors
    typedef struct packed {
        logic valid;
        logic keep;
        t_pcb pcb;
    } t_link;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  prio;
        logic [11:0] cpu;
        logic        io;
        logic [7:0]  mem;
        logic        reason;
        logic [11:0] elapsed;
    } t_req;

    typedef struct packed {
        logic    ok;
        t_pcb    pcb;
        t_pstate pstate;
    } t_res;

endpackage

// ===== design/ppsch_if.sv =====
`timescale 1ns / 1ps
// Handshake interfaces of the scheduler: command, result and configuration.
// No dependencies.
interface ppsch_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [7:0]  priority_in;
    logic [11:0] cpu_need_in;
    logic        io_flag_in;
    logic [7:0]  mem_need_in;
    logic        wait_reason;
    logic [11:0] elapsed_ticks;
    modport source (output valid, cmd, priority_in, cpu_need_in, io_flag_in,
                    mem_need_in, wait_reason, elapsed_ticks, input ready);
    modport sink   (input valid, cmd, priority_in, cpu_need_in, io_flag_in,
                    mem_need_in, wait_reason, elapsed_ticks, output ready);
endinterface

interface ppsch_res_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [15:0] proc_id;
    logic [7:0]  proc_priority;
    logic [11:0] proc_cpu_need;
    logic [11:0] proc_run_time;
    logic        proc_io_flag;
    logic [7:0]  proc_mem_need;
    logic [1:0]  proc_state;
    modport source (output valid, ok, proc_id, proc_priority, proc_cpu_need,
                    proc_run_time, proc_io_flag, proc_mem_need, proc_state,
                    input ready);
    modport sink   (input valid, ok, proc_id, proc_priority, proc_cpu_need,
                    proc_run_time, proc_io_flag, proc_mem_need, proc_state,
                    output ready);
endinterface

interface ppsch_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== design/ppsch_cell.sv =====
`timescale 1ns / 1ps
// One slot of the sorted ready chain.
// Depends on ppsch_pkg.
module ppsch_cell import ppsch_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_chain_op i_op,
    input  t_pcb      i_new,
    input  t_link     i_left,
    input  t_link     i_right,
    output t_link     o_link
);
    logic r_valid, n_valid;
    t_pcb r_pcb, n_pcb;
    logic keep;

    // sorted chain: entries with prio <= new stay put (stable order)
    assign keep   = r_valid && (r_pcb.prio <= i_new.prio);
    assign o_link = '{valid: r_valid, keep: keep, pcb: r_pcb};

    always_comb begin
        n_valid = r_valid;
        n_pcb   = r_pcb;
        case (i_op)
            OP_INS: begin
                n_valid = r_valid | i_left.valid;
                if (!keep) begin
                    n_pcb = i_left.keep ? i_new : i_left.pcb;
                end
            end
            OP_POP: begin
                n_valid = i_right.valid;
                n_pcb   = i_right.pcb;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pcb <= n_pcb;
    end
endmodule

// ===== design/ppsch_chain.sv =====
`timescale 1ns / 1ps
// Ready queue as a row of cells kept in priority order; head at cell 0.
// Depends on ppsch_pkg and ppsch_cell.
module ppsch_chain import ppsch_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_chain_op i_op,
    input  t_pcb      i_new,
    output t_link     o_head
);
    t_link links [CAPACITY];

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_link left, right;
            if (g == 0) begin : g_first
                assign left = '{valid: 1'b1, keep: 1'b1, pcb: '0};
            end else begin : g_mid_l
                assign left = links[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign right = '0;
            end else begin : g_mid_r
                assign right = links[g+1];
            end
            ppsch_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_op    (i_op),
                .i_new   (i_new),
                .i_left  (left),
                .i_right (right),
                .o_link  (links[g])
            );
        end
    endgenerate

    assign o_head = links[0];
endmodule

// ===== design/ppsch_wq.sv =====
`timescale 1ns / 1ps
// FIFO wait queue: memory filled from index 0, emptied as a whole.
// Depends on ppsch_pkg.
module ppsch_wq import ppsch_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_pcb             i_push_pcb,
    input  logic             i_clear,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_pcb             o_rd_pcb,
    output logic [CNT_W-1:0] o_count
);
    t_pcb             mem [CAPACITY];
    logic [CNT_W-1:0] r_count;
    logic             do_push;

    assign do_push = i_push && (r_count < CNT_W'(CAPACITY));
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_clear) begin
            r_count <= '0;
        end else if (do_push) begin
            r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_count[IDX_W-1:0]] <= i_push_pcb;
        end
        o_rd_pcb <= mem[i_rd_addr];
    end
endmodule

// ===== design/priority_process_scheduler.sv =====
`timescale 1ns / 1ps
// Priority process scheduler, top level.
// Depends on ppsch_pkg, ppsch_if, ppsch_chain, ppsch_wq.
//
// Takes one command request at a time and returns exactly one result per
// request. Create, schedule, suspend and time slice finish in the execute
// state: the result is registered there, then moved into the output
// register in the done state once that register is free; a new request is
// taken once the result has moved into the output register. Wake moves the
// chosen wait queue into ready one entry per cycle, limited by the single
// read port of the wait queue memory and the one sorted insert per cycle
// into the cell chain. The ready queue is a row of cells ordered by priority
// number, smaller first, equal numbers in arrival order. No clearing pass
// after reset. The configuration write (first process id) also reloads the
// id counter; write it only while the block is idle.
module priority_process_scheduler import ppsch_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ppsch_cmd_if.sink   i_cmd,
    ppsch_res_if.source o_res,
    ppsch_cfg_if.sink   i_cfg
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WAKE = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    t_req             r_req, n_req;
    t_res             r_res, n_res;
    t_res             r_out, n_out;
    logic             r_out_valid, n_out_valid;
    logic [CNT_W-1:0] r_free, n_free;
    logic [15:0]      r_next_id, n_next_id;
    t_pcb             r_run, n_run;
    logic             r_run_v, n_run_v;
    logic [CNT_W-1:0] r_widx, n_widx;
    logic             r_rdv, n_rdv;
    logic             r_first, n_first;

    // ready chain and wait queues
    t_chain_op        chain_op;
    t_pcb             chain_new;
    t_link            head;
    logic             push_io, push_mem, clr_io, clr_mem;
    t_pcb             io_rd, mem_rd, wq_rd;
    logic [CNT_W-1:0] io_cnt, mem_cnt, wcount;

    // running block with elapsed ticks added, saturating
    t_pcb             upd;
    logic [12:0]      run_sum;
    t_pcb             sliced;
    t_pcb             created;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign wcount = r_req.reason ? mem_cnt : io_cnt;
    assign wq_rd  = r_req.reason ? mem_rd : io_rd;

    always_comb begin
        run_sum = {1'b0, r_run.run} + {1'b0, r_req.elapsed};
        upd     = r_run;
        upd.run = run_sum[12] ? RUN_MAX : run_sum[11:0];
        sliced  = upd;
        if (upd.prio != PRIO_MAX) begin
            sliced.prio = upd.prio + 8'd1;
        end
        created = '{id: r_next_id, prio: r_req.prio, cpu: r_req.cpu, run: '0,
                    io: r_req.io, mem: r_req.mem};
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_free      = r_free;
        n_next_id   = r_next_id;
        n_run       = r_run;
        n_run_v     = r_run_v;
        n_widx      = r_widx;
        n_rdv       = r_rdv;
        n_first     = r_first;
        chain_op    = OP_NOP;
        chain_new   = created;
        push_io     = 1'b0;
        push_mem    = 1'b0;
        clr_io      = 1'b0;
        clr_mem     = 1'b0;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_req = '{cmd: i_cmd.cmd, prio: i_cmd.priority_in,
                              cpu: i_cmd.cpu_need_in, io: i_cmd.io_flag_in,
                              mem: i_cmd.mem_need_in, reason: i_cmd.wait_reason,
                              elapsed: i_cmd.elapsed_ticks};
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                n_res   = '0;
                case (t_cmd'(r_req.cmd))
                    CMD_CREATE: begin
                        if (r_free != '0) begin
                            n_free    = r_free - 1'b1;
                            n_next_id = r_next_id + 16'd1;
                            chain_op  = OP_INS;
                            n_res     = '{ok: 1'b1, pcb: created, pstate: PST_READY};
                        end
                    end
                    CMD_SCHEDULE: begin
                        if (head.valid) begin
                            chain_op = OP_POP;
                            n_run    = head.pcb;
                            n_run_v  = 1'b1;
                            n_res    = '{ok: 1'b1, pcb: head.pcb, pstate: PST_RUNNING};
                        end
                    end
                    CMD_SUSPEND: begin
                        if (r_run_v) begin
                            push_io  = !r_req.reason;
                            push_mem = r_req.reason;
                            n_run_v  = 1'b0;
                            if (head.valid) begin
                                chain_op = OP_POP;
                                n_run    = head.pcb;
                                n_run_v  = 1'b1;
                                n_res    = '{ok: 1'b1, pcb: head.pcb,
                                             pstate: PST_RUNNING};
                            end
                        end
                    end
                    CMD_WAKE: begin
                        if (wcount != '0) begin
                            n_widx  = '0;
                            n_rdv   = 1'b0;
                            n_first = 1'b1;
                            n_state = S_WAKE;
                        end
                    end
                    CMD_SLICE: begin
                        if (r_run_v) begin
                            chain_op  = OP_INS;
                            chain_new = sliced;
                            n_run_v   = 1'b0;
                            n_res     = '{ok: 1'b1, pcb: sliced, pstate: PST_READY};
                        end
                    end
                    default: ;
                endcase
            end
            S_WAKE: begin
                // read at r_widx now, insert what was read last cycle
                if (r_widx != wcount) begin
                    n_widx = r_widx + 1'b1;
                    n_rdv  = 1'b1;
                end else begin
                    n_rdv = 1'b0;
                end
                if (r_rdv) begin
                    chain_op  = OP_INS;
                    chain_new = wq_rd;
                    if (r_first) begin
                        n_res   = '{ok: 1'b1, pcb: wq_rd, pstate: PST_READY};
                        n_first = 1'b0;
                    end
                end else if (r_widx == wcount) begin
                    clr_io  = !r_req.reason;
                    clr_mem = r_req.reason;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (i_cfg.valid) begin
            n_next_id = i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_free      <= CNT_W'(CAPACITY);
            r_next_id   <= RESET_FIRST_ID;
            r_run_v     <= 1'b0;
            r_rdv       <= 1'b0;
            r_first     <= 1'b0;
            r_widx      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_free      <= n_free;
            r_next_id   <= n_next_id;
            r_run_v     <= n_run_v;
            r_rdv       <= n_rdv;
            r_first     <= n_first;
            r_widx      <= n_widx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_res <= n_res;
        r_out <= n_out;
        r_run <= n_run;
    end

    ppsch_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (chain_op),
        .i_new   (chain_new),
        .o_head  (head)
    );

    ppsch_wq u_io_wq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push_io),
        .i_push_pcb (upd),
        .i_clear    (clr_io),
        .i_rd_addr  (r_widx[IDX_W-1:0]),
        .o_rd_pcb   (io_rd),
        .o_count    (io_cnt)
    );

    ppsch_wq u_mem_wq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push_mem),
        .i_push_pcb (upd),
        .i_clear    (clr_mem),
        .i_rd_addr  (r_widx[IDX_W-1:0]),
        .o_rd_pcb   (mem_rd),
        .o_count    (mem_cnt)
    );

    assign o_res.valid         = r_out_valid;
    assign o_res.ok            = r_out.ok;
    assign o_res.proc_id       = r_out.pcb.id;
    assign o_res.proc_priority = r_out.pcb.prio;
    assign o_res.proc_cpu_need = r_out.pcb.cpu;
    assign o_res.proc_run_time = r_out.pcb.run;
    assign o_res.proc_io_flag  = r_out.pcb.io;
    assign o_res.proc_mem_need = r_out.pcb.mem;
    assign o_res.proc_state    = r_out.pstate;
endmodule

// ===== design/ppsch_chk.sv =====
`timescale 1ns / 1ps
// Port-level checks of the scheduler and their bind to the top level.
// Depends on ppsch_pkg and priority_process_scheduler.
module ppsch_chk import ppsch_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_ok,
    input logic [15:0] i_id,
    input logic [7:0]  i_prio,
    input logic [1:0]  i_pstate
);
    // a failed request reports an all-zero block
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_ok |-> i_id == '0 && i_prio == '0 && i_pstate == PST_WAITING)
        else $error("failed result carries data");

    // a good result is ready or running, never waiting
    a_ok_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_ok |-> i_pstate == PST_READY || i_pstate == PST_RUNNING)
        else $error("good result in waiting state");

    // one request at a time
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while busy");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_id) && $stable(i_ok))
        else $error("stalled result changed");
endmodule

bind priority_process_scheduler ppsch_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_ok        (o_res.ok),
    .i_id        (o_res.proc_id),
    .i_prio      (o_res.proc_priority),
    .i_pstate    (o_res.proc_state)
);

// ===== bench/tb_priority_process_scheduler.sv =====
`timescale 1ns / 1ps
// Testbench of priority_process_scheduler: random and directed command
// requests checked against an in-bench scheduler predictor.
// Depends on ppsch_pkg, ppsch_if and the scheduler RTL.
module tb_priority_process_scheduler;
    import ppsch_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #5 i_clk = ~i_clk;

    ppsch_cmd_if cmd_ch();
    ppsch_res_if res_ch();
    ppsch_cfg_if cfg_ch();

    priority_process_scheduler i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch.sink),
        .o_res  (res_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    // ---------------------------------------------------------------
    // Scheduler predictor: pool, sorted ready queue, two FIFO wait
    // queues and the running slot.
    // ---------------------------------------------------------------
    int   pool_free;
    logic [15:0] id_next;
    t_pcb ready_q[$];
    t_pcb io_wait_q[$];
    t_pcb mem_wait_q[$];
    t_pcb run_pcb;
    bit   run_busy;
    t_res expected_results[$];

    // stable insert: after every entry with a priority number <= new one
    function automatic void ready_add(t_pcb b);
        int pos;
        pos = ready_q.size();
        if (pos >= CAPACITY) return;
        while (pos > 0 && ready_q[pos-1].prio > b.prio) pos--;
        ready_q.insert(pos, b);
    endfunction

    function automatic logic [11:0] run_sum(logic [11:0] a, logic [11:0] b);
        logic [12:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[12] ? RUN_MAX : s[11:0];
    endfunction

    function automatic t_res predict_command(t_req r);
        t_res res;
        t_pcb b;
        res = '0;
        case (r.cmd)
            CMD_CREATE: begin
                if (pool_free > 0 && ready_q.size() < CAPACITY) begin
                    pool_free--;
                    b.id = id_next;
                    id_next = id_next + 16'd1;
                    b.prio = r.prio; b.cpu = r.cpu; b.run = '0;
                    b.io = r.io; b.mem = r.mem;
                    ready_add(b);
                    res = '{ok: 1'b1, pcb: b, pstate: PST_READY};
                end
            end
            CMD_SCHEDULE: begin
                // a running block is dropped without returning to the pool
                if (ready_q.size() > 0) begin
                    run_pcb = ready_q[0];
                    ready_q.delete(0);
                    run_busy = 1'b1;
                    res = '{ok: 1'b1, pcb: run_pcb, pstate: PST_RUNNING};
                end
            end
            CMD_SUSPEND: begin
                if (run_busy) begin
                    b = run_pcb;
                    b.run = run_sum(b.run, r.elapsed);
                    if (r.reason) begin
                        if (mem_wait_q.size() < CAPACITY)
                            mem_wait_q.insert(mem_wait_q.size(), b);
                    end else begin
                        if (io_wait_q.size() < CAPACITY)
                            io_wait_q.insert(io_wait_q.size(), b);
                    end
                    run_busy = 1'b0;
                    // empty ready queue: block is still parked, ok stays 0
                    if (ready_q.size() > 0) begin
                        run_pcb = ready_q[0];
                        ready_q.delete(0);
                        run_busy = 1'b1;
                        res = '{ok: 1'b1, pcb: run_pcb, pstate: PST_RUNNING};
                    end
                end
            end
            CMD_WAKE: begin
                if (r.reason && mem_wait_q.size() > 0) begin
                    res = '{ok: 1'b1, pcb: mem_wait_q[0], pstate: PST_READY};
                    foreach (mem_wait_q[i]) ready_add(mem_wait_q[i]);
                    mem_wait_q.delete();
                end else if (!r.reason && io_wait_q.size() > 0) begin
                    res = '{ok: 1'b1, pcb: io_wait_q[0], pstate: PST_READY};
                    foreach (io_wait_q[i]) ready_add(io_wait_q[i]);
                    io_wait_q.delete();
                end
            end
            CMD_SLICE: begin
                if (run_busy) begin
                    b = run_pcb;
                    b.run = run_sum(b.run, r.elapsed);
                    if (b.prio != PRIO_MAX) b.prio++;
                    run_busy = 1'b0;
                    ready_add(b);
                    res = '{ok: 1'b1, pcb: b, pstate: PST_READY};
                end
            end
            default: ;   // unknown command: ok=0, nothing changes
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Request queue and driver. Each entry carries a kind: a request,
    // a drain marker or a config write.
    // ---------------------------------------------------------------
    typedef struct {
        int   kind;       // 0 request, 1 wait until idle, 2 config write
        t_req req;
        logic [15:0] cfg_val;
    } t_pending;

    localparam int KIND_REQ   = 0;
    localparam int KIND_DRAIN = 1;
    localparam int KIND_CFG   = 2;

    t_pending pending_reqs[$];
    int   burst_left = 0;
    int   gap_left = 0;
    int   idle_hold = 0;
    int   n_accepted = 0;
    int   n_results = 0;
    int   n_ok = 0;
    int   n_errors = 0;

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.cmd = '0; cmd_ch.priority_in = '0; cmd_ch.cpu_need_in = '0;
        cmd_ch.io_flag_in = 1'b0; cmd_ch.mem_need_in = '0;
        cmd_ch.wait_reason = 1'b0; cmd_ch.elapsed_ticks = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        res_ch.ready = 1'b0;
    end

    // the predictor runs when a request is accepted at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready) begin
            t_req r;
            r.cmd = cmd_ch.cmd; r.prio = cmd_ch.priority_in;
            r.cpu = cmd_ch.cpu_need_in; r.io = cmd_ch.io_flag_in;
            r.mem = cmd_ch.mem_need_in; r.reason = cmd_ch.wait_reason;
            r.elapsed = cmd_ch.elapsed_ticks;
            expected_results.insert(expected_results.size(), predict_command(r));
            n_accepted++;
        end
        if (i_rst_n && cfg_ch.valid && cfg_ch.ready) begin
            id_next = cfg_ch.data;
        end
    end

    // accept flags captured at the rising edge, used by the driver
    bit cmd_took, cfg_took;
    always @(posedge i_clk) begin
        cmd_took <= i_rst_n && cmd_ch.valid && cmd_ch.ready;
        cfg_took <= i_rst_n && cfg_ch.valid && cfg_ch.ready;
    end

    // driver: at the falling edge, after the rising edge settled accepts
    always @(negedge i_clk) begin
        t_pending p;
        bit drive;
        drive = 1'b0;
        if (i_rst_n) begin
            if (cfg_took) cfg_ch.valid <= 1'b0;
            if (cmd_took) pending_reqs.delete(0);
            if (cmd_took || !cmd_ch.valid) begin
                if (idle_hold > 0) idle_hold <= idle_hold - 1;
                else if (cfg_ch.valid && !cfg_took) ;
                else if (pending_reqs.size() > 0) begin
                    p = pending_reqs[0];
                    if (p.kind == KIND_REQ) begin
                        if (gap_left > 0) gap_left <= gap_left - 1;
                        else begin
                            drive = 1'b1;
                            cmd_ch.cmd <= p.req.cmd;
                            cmd_ch.priority_in <= p.req.prio;
                            cmd_ch.cpu_need_in <= p.req.cpu;
                            cmd_ch.io_flag_in <= p.req.io;
                            cmd_ch.mem_need_in <= p.req.mem;
                            cmd_ch.wait_reason <= p.req.reason;
                            cmd_ch.elapsed_ticks <= p.req.elapsed;
                            if (burst_left > 0) burst_left <= burst_left - 1;
                            else begin
                                burst_left <= $urandom_range(0, 20);
                                gap_left <= ($urandom_range(0, 3) == 0) ? 0
                                            : $urandom_range(1, 12);
                            end
                        end
                    end else if (!cmd_took && expected_results.size() == 0) begin
                        // idle: everything answered
                        if (p.kind == KIND_CFG) begin
                            cfg_ch.valid <= 1'b1;
                            cfg_ch.data <= p.cfg_val;
                        end
                        pending_reqs.delete(0);
                        idle_hold <= 80;
                    end
                end
                cmd_ch.valid <= drive;
            end
        end
    end

    // receiver stall pattern: alternate stretches of full and patchy ready
    int stall_phase = 0;
    always @(negedge i_clk) begin
        stall_phase <= (stall_phase + 1) % 300;
        if (stall_phase < 100) res_ch.ready <= 1'b1;
        else if (stall_phase < 200) res_ch.ready <= ($urandom_range(0, 2) != 0);
        else res_ch.ready <= ($urandom_range(0, 5) == 0);
    end

    // monitor: compare every accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            t_res e;
            n_results++;
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding");
                n_errors++;
            end else begin
                e = expected_results[0];
                expected_results.delete(0);
                if (e.ok) n_ok++;
                if (res_ch.ok !== e.ok) begin
                    $error("ok: expected %0d actual %0d", e.ok, res_ch.ok); n_errors++;
                end
                if (res_ch.proc_id !== e.pcb.id) begin
                    $error("proc_id: expected %0d actual %0d", e.pcb.id, res_ch.proc_id);
                    n_errors++;
                end
                if (res_ch.proc_priority !== e.pcb.prio) begin
                    $error("proc_priority: expected %0d actual %0d",
                           e.pcb.prio, res_ch.proc_priority);
                    n_errors++;
                end
                if (res_ch.proc_cpu_need !== e.pcb.cpu) begin
                    $error("proc_cpu_need: expected %0d actual %0d",
                           e.pcb.cpu, res_ch.proc_cpu_need);
                    n_errors++;
                end
                if (res_ch.proc_run_time !== e.pcb.run) begin
                    $error("proc_run_time: expected %0d actual %0d",
                           e.pcb.run, res_ch.proc_run_time);
                    n_errors++;
                end
                if (res_ch.proc_io_flag !== e.pcb.io) begin
                    $error("proc_io_flag: expected %0d actual %0d",
                           e.pcb.io, res_ch.proc_io_flag);
                    n_errors++;
                end
                if (res_ch.proc_mem_need !== e.pcb.mem) begin
                    $error("proc_mem_need: expected %0d actual %0d",
                           e.pcb.mem, res_ch.proc_mem_need);
                    n_errors++;
                end
                if (res_ch.proc_state !== e.pstate) begin
                    $error("proc_state: expected %0d actual %0d",
                           e.pstate, res_ch.proc_state);
                    n_errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    function automatic t_req make_req(logic [2:0] c, logic [7:0] p, logic [11:0] cpu,
                                      logic io, logic [7:0] mem, logic rsn,
                                      logic [11:0] el);
        t_req r;
        r.cmd = c; r.prio = p; r.cpu = cpu; r.io = io; r.mem = mem;
        r.reason = rsn; r.elapsed = el;
        return r;
    endfunction

    task automatic add_req(t_req r);
        t_pending p;
        p.kind = KIND_REQ; p.req = r; p.cfg_val = '0;
        pending_reqs.insert(pending_reqs.size(), p);
    endtask

    task automatic add_marker(int k, logic [15:0] v);
        t_pending p;
        p.kind = k; p.req = '0; p.cfg_val = v;
        pending_reqs.insert(pending_reqs.size(), p);
    endtask

    function automatic t_req random_req();
        t_req r;
        int sel;
        r.prio = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(250, 255))
                 : 8'($urandom_range(0, 255));
        r.cpu = 12'($urandom_range(0, 4095));
        r.io = 1'($urandom_range(0, 1));
        r.mem = 8'($urandom_range(0, 255));
        r.reason = 1'($urandom_range(0, 1));
        r.elapsed = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(3000, 4095))
                    : 12'($urandom_range(0, 4095));
        sel = $urandom_range(0, 99);
        if (sel < 26) r.cmd = CMD_CREATE;
        else if (sel < 44) r.cmd = CMD_SCHEDULE;
        else if (sel < 64) r.cmd = CMD_SUSPEND;
        else if (sel < 76) r.cmd = CMD_WAKE;
        else if (sel < 98) r.cmd = CMD_SLICE;
        else r.cmd = 3'($urandom_range(5, 7));
        return r;
    endfunction

    int stall_cycles = 0;
    int last_accepts = 0;

    initial begin
        t_req r;
        pool_free = CAPACITY;
        id_next = RESET_FIRST_ID;
        run_busy = 1'b0;

        // directed: every command, extremes and each corner
        add_req(make_req(CMD_SCHEDULE, 0, 0, 0, 0, 0, 0));        // empty ready
        add_req(make_req(CMD_SUSPEND, 0, 0, 0, 0, 0, 5));         // nothing runs
        add_req(make_req(CMD_SLICE, 0, 0, 0, 0, 0, 5));           // nothing runs
        add_req(make_req(CMD_WAKE, 0, 0, 0, 0, 1, 0));            // empty wait
        add_req(make_req(CMD_CREATE, 8'hFF, 12'hFFF, 1, 8'hFF, 0, 0));
        add_req(make_req(CMD_CREATE, 8'h00, 12'h000, 0, 8'h00, 1, 12'hFFF));
        add_req(make_req(CMD_CREATE, 8'h00, 12'h5A5, 1, 8'hA5, 0, 0)); // tie
        add_req(make_req(CMD_SCHEDULE, 0, 0, 0, 0, 0, 0));
        add_req(make_req(CMD_SLICE, 0, 0, 0, 0, 0, 12'hFFF));
        add_req(make_req(CMD_SCHEDULE, 0, 0, 0, 0, 0, 0));        // nothing runs
        add_req(make_req(CMD_SUSPEND, 0, 0, 0, 0, 0, 12'hFFF));
        add_req(make_req(CMD_SUSPEND, 0, 0, 0, 0, 1, 12'hFFF));
        add_req(make_req(CMD_SUSPEND, 0, 0, 0, 0, 1, 12'h001));   // ready empty
        add_req(make_req(CMD_WAKE, 0, 0, 0, 0, 0, 0));
        add_req(make_req(CMD_WAKE, 0, 0, 0, 0, 1, 0));
        add_req(make_req(CMD_SCHEDULE, 0, 0, 0, 0, 0, 0));
        add_req(make_req(CMD_SLICE, 0, 0, 0, 0, 0, 12'hFFF));     // saturate run
        add_req(make_req(3'd5, 0, 0, 0, 0, 0, 0));
        add_req(make_req(3'd7, 8'hFF, 12'hFFF, 1, 8'hFF, 1, 12'hFFF));
        add_marker(KIND_CFG, 16'hFFFF);                            // id wraps
        add_req(make_req(CMD_CREATE, 8'h80, 12'h123, 0, 8'h12, 0, 0));
        add_req(make_req(CMD_CREATE, 8'h80, 12'h456, 1, 8'h34, 0, 0));
        add_marker(KIND_CFG, 16'h0000);

        // random phases with config writes between them; the last
        // phase exhausts the pool so creates with no free block occur
        for (int ph = 0; ph < 9; ph++) begin
            for (int k = 0; k < 150; k++) begin
                r = random_req();
                if (ph == 8 && k < 70) r.cmd = CMD_CREATE;
                add_req(r);
            end
            add_marker(KIND_DRAIN, 0);                             // sender waits
            if (ph < 8) add_marker(KIND_CFG, (ph == 3) ? 16'd1000 : 16'($urandom));
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // wait for every request to be accepted and every result back
        while (pending_reqs.size() > 0 || cmd_ch.valid || expected_results.size() > 0) begin
            @(posedge i_clk);
            if (n_accepted + n_results != last_accepts) begin
                last_accepts = n_accepted + n_results;
                stall_cycles = 0;
            end else if (++stall_cycles > 20000) begin
                $display("timeout: %0d requests pending, %0d results outstanding",
                         pending_reqs.size(), expected_results.size());
                $display("tb_priority_process_scheduler: done, errors");
                $finish;
            end
        end
        repeat (100) @(posedge i_clk);
        if (expected_results.size() != 0) n_errors++;

        $display("covered %0d requests of all five commands plus unknown codes,",
                 n_accepted);
        $display("%0d results (%0d acting on a block), id register rewritten 10 times",
                 n_results, n_ok);
        if (n_errors == 0) begin
            $display("tb_priority_process_scheduler: done, clean");
        end else begin
            $display("tb_priority_process_scheduler: done, errors");
        end
        $finish;
    end

    // a stray result after the drain is caught by the monitor
endmodule
